// File: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CHK_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Condition must never be true outside reset.
`define CHK_NEVER(lbl, clk, rst_n, cond) \
	`CHK_ASSERT(lbl, clk, rst_n, !(cond))

`endif

// File: rtl/sitda_pkg.sv
package sitda_pkg;

	localparam int VALUE_WIDTH   = 64;
	localparam int IN_TDATA_W    = 64;
	localparam int OUT_TDATA_W   = 8;
	localparam int CHAR_W        = 6;
	localparam int BITS_PER_STEP = 4;

	localparam logic [63:0] RADIX = 64'd10;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

	// decimal digits needed for the largest magnitude 2^(w-1)
	function automatic int digits_for(input int w);
		logic [63:0] v;
		int n;
		v = 64'd1 << (w - 1);
		n = 0;
		for (int i = 0; i < 21; i++) begin
			if (v != 64'd0) begin
				v = v / RADIX;
				n = n + 1;
			end
		end
		return n;
	endfunction

	localparam int NUM_DIGITS = digits_for(VALUE_WIDTH);
	localparam int BCD_W      = 4 * NUM_DIGITS;
	localparam int IDX_W      = $clog2(NUM_DIGITS);
	localparam int STEPS      = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
	localparam int MAG_W      = STEPS * BITS_PER_STEP;
	localparam int CNT_W      = $clog2(STEPS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_FIND,
		ST_SIGN,
		ST_EMIT
	} st_t;

	typedef struct packed {
		logic load;
		logic shift;
		logic find;
		logic dec;
		logic sel_sign;
	} dp_cmd_t;

	typedef struct packed {
		logic last_step;
		logic idx_zero;
		logic neg;
	} dp_stat_t;

endpackage

// File: rtl/sitda_ctrl.sv
module sitda_ctrl import sitda_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);

	st_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.shift = 1'b1;
				if (stat.last_step) begin
					state_d = ST_FIND;
				end
			end
			ST_FIND: begin
				cmd.find = 1'b1;
				state_d  = stat.neg ? ST_SIGN : ST_EMIT;
			end
			ST_SIGN: begin
				out_valid    = 1'b1;
				cmd.sel_sign = 1'b1;
				if (out_ready) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (stat.idx_zero) begin
						state_d = ST_IDLE;
					end else begin
						cmd.dec = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/sitda_dp.sv
module sitda_dp import sitda_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [IN_TDATA_W-1:0] value,
	input  dp_cmd_t               cmd,
	output dp_stat_t              stat,
	output logic [CHAR_W-1:0]     text_char,
	output logic                  last
);

	localparam int DD_W = BCD_W + MAG_W;

	logic [VALUE_WIDTH-1:0] raw;
	logic [VALUE_WIDTH-1:0] mag;
	logic                   neg_in;

	logic [BCD_W-1:0] bcd_q;
	logic [MAG_W-1:0] mag_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] idx_q;

	logic [DD_W-1:0]  dd_next;
	logic [IDX_W-1:0] msd;
	logic [3:0]       digit;

	// one binary-to-BCD bit: add 3 to digits of 5 or more, then shift
	function automatic logic [DD_W-1:0] dd_bit(input logic [DD_W-1:0] x);
		logic [DD_W-1:0] y;
		y = x;
		for (int d = 0; d < NUM_DIGITS; d++) begin
			if (y[MAG_W + 4*d +: 4] >= 4'd5) begin
				y[MAG_W + 4*d +: 4] = y[MAG_W + 4*d +: 4] + 4'd3;
			end
		end
		return y << 1;
	endfunction

	assign raw    = value[VALUE_WIDTH-1:0];
	assign neg_in = raw[VALUE_WIDTH-1];
	assign mag    = neg_in ? (~raw + 1'b1) : raw;

	always_comb begin
		dd_next = {bcd_q, mag_q};
		for (int b = 0; b < BITS_PER_STEP; b++) begin
			dd_next = dd_bit(dd_next);
		end
	end

	always_comb begin
		msd = '0;
		for (int d = 0; d < NUM_DIGITS; d++) begin
			if (bcd_q[4*d +: 4] != 4'd0) begin
				msd = IDX_W'(d);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			if (cmd.load) begin
				cnt_q <= CNT_W'(STEPS);
			end else if (cmd.shift) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.find) begin
				idx_q <= msd;
			end else if (cmd.dec) begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bcd_q <= '0;
			mag_q <= MAG_W'(mag);
			neg_q <= neg_in;
		end else if (cmd.shift) begin
			{bcd_q, mag_q} <= dd_next;
		end
	end

	assign digit = bcd_q[4*idx_q +: 4];

	assign text_char = cmd.sel_sign ? CHAR_MINUS : (CHAR_ZERO + {2'b00, digit});
	assign last      = !cmd.sel_sign && (idx_q == '0);

	assign stat.last_step = (cnt_q == CNT_W'(1));
	assign stat.idx_zero  = (idx_q == '0);
	assign stat.neg       = neg_q;

endmodule

// File: rtl/signed_int_to_decimal_ascii_core.sv
// Signed integer to decimal ASCII text.
// Slave stream: s_tdata carries one two's-complement integer per transfer
// (low VALUE_WIDTH bits used). s_tready is high only while the core is idle.
// Master stream: one character per transfer, most significant first; a '-'
// leads negative values, zero gives a single '0', m_tlast marks the final
// character of each number.
// After the input transfer the value goes through binary-to-BCD conversion,
// 4 bits per step (ST_CONV), then a leading-digit search (ST_FIND), before
// the first character is valid. Characters then go out one per cycle while
// m_tready is high. A number gives N characters, 1 to 20.
// A stalled receiver holds the current character and m_tlast stable; the
// core resumes when m_tready returns. Reset returns the core to idle and
// drops any number in progress; nothing else is retained between numbers.
module signed_int_to_decimal_ascii_core import sitda_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // [63:0] value
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // [5:0] text_char, [7:6] zero
	output logic                   m_tlast   // last
);

	dp_cmd_t           cmd;
	dp_stat_t          stat;
	logic [CHAR_W-1:0] text_char;

	sitda_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.stat      (stat)
	);

	sitda_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (s_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.text_char (text_char),
		.last      (m_tlast)
	);

	assign m_tdata = {(OUT_TDATA_W - CHAR_W)'(0), text_char};

endmodule

// File: rtl/sitda_chk.sv
`include "assert_macros.svh"

module sitda_chk import sitda_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   m_tlast
);

	`CHK_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
	`CHK_NEVER(a_no_intake_while_out, clk, arst_n, s_tready && m_tvalid)
	`CHK_ASSERT(a_char_range, clk, arst_n, m_tvalid |-> (m_tdata == 8'd45 || (m_tdata >= 8'd48 && m_tdata <= 8'd57)))
	`CHK_NEVER(a_minus_not_last, clk, arst_n, m_tvalid && m_tlast && m_tdata == 8'd45)
	`CHK_ASSERT(a_gap_after_last, clk, arst_n, m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready)

endmodule

bind signed_int_to_decimal_ascii_core sitda_chk u_sitda_chk (.*);

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import sitda_pkg::*;

	localparam int MAX_DIGITS     = 19;
	localparam int RANDOM_ITEMS   = 350;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 40;
	localparam int BUSY_PCT_LOW   = 13;
	localparam int BUSY_PCT_HIGH  = 85;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} text_beat_t;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;
	logic                   m_tready = 1'b0;
	logic                   s_tready;
	logic                   m_tvalid;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;

	logic [IN_TDATA_W-1:0] pending_values[$];
	text_beat_t            expected_text[$];

	int total_items;
	int accepted_count = 0;
	int pressure_at;
	int hold_left      = 0;
	bit pressure_done  = 1'b0;
	int mismatches     = 0;
	int char_count     = 0;
	int negative_count = 0;
	int zero_count     = 0;
	int longest_text   = 0;

	signed_int_to_decimal_ascii_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #6 clk = ~clk;

	// decimal text of one integer, sign first, digits most significant first
	function automatic void predict_text(input logic [IN_TDATA_W-1:0] word);
		logic [VALUE_WIDTH-1:0] raw;
		logic [VALUE_WIDTH-1:0] mag;
		logic [63:0]            rem;
		logic [3:0]             digit_buf[MAX_DIGITS];
		logic                   neg;
		int                     nd;
		int                     len;
		raw = word[VALUE_WIDTH-1:0];
		neg = raw[VALUE_WIDTH-1];
		mag = neg ? (~raw + 1'b1) : raw;
		nd  = 0;
		do begin
			rem = mag % RADIX;
			digit_buf[nd] = rem[3:0];
			nd++;
			mag = mag / RADIX;
		end while (mag != 0 && nd < MAX_DIGITS);
		len = nd;
		if (neg) begin
			expected_text.push_back('{code: CHAR_MINUS, last: 1'b0});
			negative_count++;
			len++;
		end
		for (int k = nd - 1; k >= 0; k--) begin
			expected_text.push_back('{code: CHAR_ZERO + CHAR_W'(digit_buf[k]), last: (k == 0)});
		end
		if (raw == 0)
			zero_count++;
		if (len > longest_text)
			longest_text = len;
	endfunction

	// busy share per side: sender eager / receiver slow, then swapped, then free running
	function automatic int busy_pct(input bit sender_side);
		if (accepted_count < total_items / 3)
			return sender_side ? BUSY_PCT_LOW : BUSY_PCT_HIGH;
		else if (accepted_count < (2 * total_items) / 3)
			return sender_side ? BUSY_PCT_HIGH : BUSY_PCT_LOW;
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_text(s_tdata);
				void'(pending_values.pop_front());
				accepted_count <= accepted_count + 1;
			end
			if (!(s_tvalid && !s_tready)) begin
				if (pending_values.size() != 0 && $urandom_range(0, 99) >= busy_pct(1'b1)) begin
					s_tvalid <= 1'b1;
					s_tdata  <= pending_values[0];
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!pressure_done && accepted_count >= pressure_at) begin
			pressure_done <= 1'b1;
			hold_left     <= HOLD_CYCLES;
			m_tready      <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= busy_pct(1'b0));
		end
	end

	always @(posedge clk) begin
		text_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			char_count++;
			if (expected_text.size() == 0) begin
				$display("%0t: unexpected transfer tdata=%h tlast=%b", $time, m_tdata, m_tlast);
				mismatches++;
			end else begin
				want = expected_text.pop_front();
				if (m_tdata !== {{(OUT_TDATA_W-CHAR_W){1'b0}}, want.code}) begin
					$display("%0t: text_char expected %0d actual %0d (tdata %h)",
						$time, want.code, m_tdata[CHAR_W-1:0], m_tdata);
					mismatches++;
				end
				if (m_tlast !== want.last) begin
					$display("%0t: last expected %b actual %b", $time, want.last, m_tlast);
					mismatches++;
				end
			end
		end
	end

	initial begin
		logic [63:0]           pow10[MAX_DIGITS];
		logic [IN_TDATA_W-1:0] wmask;
		logic [IN_TDATA_W-1:0] wmin;
		logic [IN_TDATA_W-1:0] v;
		int                    sel;
		int                    nbits;

		wmask = {IN_TDATA_W{1'b1}} >> (IN_TDATA_W - VALUE_WIDTH);
		wmin  = 64'd1 << (VALUE_WIDTH - 1);
		pow10[0] = 64'd1;
		for (int k = 1; k < MAX_DIGITS; k++)
			pow10[k] = pow10[k-1] * RADIX;

		// directed: zero, one digit, digit count edges, width extremes, bit patterns
		pending_values = '{64'd0, 64'd1, -64'sd1, 64'd9, 64'd10, -64'sd9, -64'sd10,
			64'd99, 64'd100, 64'd12345, 64'h0000_0001_0000_0000, -64'sh1_0000_0000,
			pow10[18], pow10[18] - 1, -pow10[18], 64'd1000000000,
			-64'sd1234567890123456789, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
			wmask >> 1, wmin, wmin + 1,
			(~wmask) | wmin, (~wmask) | (wmask >> 1)};

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			sel = $urandom_range(0, 9);
			if (sel < 4) begin
				v = {$urandom, $urandom};
			end else if (sel < 8) begin
				nbits = $urandom_range(1, 63);
				v = {$urandom, $urandom} & ((64'd1 << nbits) - 1);
				if ($urandom_range(0, 1))
					v = -v;
			end else if (sel == 8) begin
				v = pow10[$urandom_range(0, MAX_DIGITS - 1)] + $urandom_range(0, 2) - 1;
				if ($urandom_range(0, 1))
					v = -v;
			end else begin
				v = IN_TDATA_W'($urandom_range(0, 20));
				if ($urandom_range(0, 1))
					v = -v;
			end
			pending_values.push_back(v);
		end
		total_items = pending_values.size();
		pressure_at = (2 * total_items) / 3 + 5;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_values.size() != 0 || s_tvalid || expected_text.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("converted %0d integers (%0d negative, %0d zero) into %0d characters",
			accepted_count, negative_count, zero_count, char_count);
		$display("longest text %0d characters, one long output stall of %0d cycles",
			longest_text, HOLD_CYCLES);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
